@@ hdl/scpc_pkg.sv @@
// Shared types and constants of the sampler channel play controller.
`default_nettype none

package scpc_pkg;

  // Channel play status.
  typedef enum logic [1:0] {
    StOff    = 2'd0,
    StPlay   = 2'd1,
    StWait   = 2'd2,
    StEnding = 2'd3
  } status_e;

  // Event kind carried on the input side-band.
  typedef enum logic [2:0] {
    EvPress   = 3'd0,
    EvKill    = 3'd1,
    EvRelease = 3'd2,
    EvSeqStop = 3'd3,
    EvLoad    = 3'd4
  } event_e;

  // Player modes; codes above endless are treated alike.
  localparam logic [2:0] PmBasic      = 3'd0;
  localparam logic [2:0] PmBasicPause = 3'd1;
  localparam logic [2:0] PmPress      = 3'd2;
  localparam logic [2:0] PmRetrig     = 3'd3;
  localparam logic [2:0] PmEndless    = 3'd4;

  // Render commands.
  localparam logic [1:0] RcNone   = 2'd0;
  localparam logic [1:0] RcRewind = 2'd1;
  localparam logic [1:0] RcStop   = 2'd2;

  // Quantizer requests.
  localparam logic [1:0] QrNone   = 2'd0;
  localparam logic [1:0] QrPlay   = 2'd1;
  localparam logic [1:0] QrRewind = 2'd2;
  localparam logic [1:0] QrClear  = 2'd3;

  // Quantizer action code bases.
  localparam logic [13:0] ActionPlayBase   = 14'd0;
  localparam logic [13:0] ActionRewindBase = 14'd10000;

  // Configuration register indexes.
  localparam logic [1:0] CfgChannelId     = 2'd0;
  localparam logic [1:0] CfgStopOnSeqHalt = 2'd1;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned ChanW     = 12;
  localparam int unsigned VelW      = 7;
  localparam int unsigned VolW      = 16;
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 40;

  // Input beat payload; the last member sits in the lowest bits.
  typedef struct packed {
    logic [1:0]      new_status;
    logic            reading_actions;
    logic            quantize_pending;
    logic            velocity_as_volume;
    logic            is_loop;
    logic            can_quantize;
    logic [VelW-1:0] velocity;
    logic [2:0]      player_mode;
  } in_data_t;

  // Input item as seen by the event logic.
  typedef struct packed {
    event_e   mode;
    in_data_t data;
  } in_item_t;

  // Result beat payload; the last member sits in the lowest bits.
  typedef struct packed {
    logic            rewind_to_start;
    logic [VolW-1:0] volume;
    logic            volume_valid;
    logic [13:0]     action_id;
    logic [1:0]      quantize_request;
    logic [1:0]      render_command;
    status_e         status;
  } out_data_t;

  localparam int unsigned InDataW  = $bits(in_data_t);
  localparam int unsigned OutDataW = $bits(out_data_t);

endpackage

`default_nettype wire

@@ hdl/sample_channel_play_control.sv @@
// Top level of the sampler channel play controller.
//
// Events enter on the slave stream: the event kind rides on s_axis_tuser and
// the event fields on s_axis_tdata. Every event yields exactly one result beat
// on the master stream with the new status and any render command, quantizer
// request, volume update or hard rewind. Configuration registers (channel id,
// stop on sequencer halt) are written over the cfg channel, index plus data;
// a write is taken in every cycle.
// An accepted event passes through the input register, then the event
// decode and the result register, which holds its result beat.
// Throughput is one event per cycle while the receiver does not stall; the
// only loop is the two-bit status register feeding the decode of the next
// event.
// When the receiver stalls, the held result stays in place, one more event
// waits in the input register, and s_axis_tready then falls until the result
// is taken.
// Reset empties both registers, sets the status to off and clears the
// configuration registers.
`default_nettype none

module sample_channel_play_control #(
  parameter int unsigned VELOCITY_MAX = 127
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: player_mode[2:0], velocity[9:3], can_quantize[10],
  // is_loop[11], velocity_as_volume[12], quantize_pending[13],
  // reading_actions[14], new_status[16:15]; zero fill above.
  input  wire logic [scpc_pkg::InTdataW-1:0]  s_axis_tdata,
  // Fields from bit 0: mode[2:0].
  input  wire logic [2:0]                     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // Fields from bit 0: status[1:0], render_command[3:2],
  // quantize_request[5:4], action_id[19:6], volume_valid[20],
  // volume[36:21], rewind_to_start[37]; zero fill above.
  output logic [scpc_pkg::OutTdataW-1:0]      m_axis_tdata,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [scpc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [scpc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import scpc_pkg::*;

  logic [ChanW-1:0] chan_id_q;
  logic             stop_on_halt_q;
  in_item_t         in_item;
  in_item_t         stage_item;
  logic             stage_valid;
  logic             out_free;
  logic             advance;
  out_data_t        result;
  out_data_t        out_result;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_id_q      <= '0;
      stop_on_halt_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgChannelId:     chan_id_q      <= cfg_data_i[ChanW-1:0];
        CfgStopOnSeqHalt: stop_on_halt_q <= cfg_data_i[0];
        default: begin
          chan_id_q <= chan_id_q;
        end
      endcase
    end
  end

  assign in_item.mode = event_e'(s_axis_tuser);
  assign in_item.data = in_data_t'(s_axis_tdata[InDataW-1:0]);

  // An event moves on when the result register has room.
  assign advance = stage_valid && out_free;

  scpc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  scpc_event_core #(
    .VELOCITY_MAX (VELOCITY_MAX)
  ) u_event_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .advance_i          (advance),
    .item_i             (stage_item),
    .channel_id_i       (chan_id_q),
    .stop_on_seq_halt_i (stop_on_halt_q),
    .result_o           (result)
  );

  scpc_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {{(OutTdataW - OutDataW){1'b0}}, out_result};

endmodule

`default_nettype wire

@@ hdl/scpc_in_stage.sv @@
// Input register stage that holds one accepted event beat.
`default_nettype none

module scpc_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire scpc_pkg::in_item_t item_i,
  input  wire logic              advance_i,
  output logic                   valid_o,
  output scpc_pkg::in_item_t     item_o
);
  import scpc_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  // The slot takes a new beat when empty or when its beat moves on.
  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/scpc_event_core.sv @@
// Event decode, velocity to volume table and the play status register.
`default_nettype none

module scpc_event_core #(
  parameter int unsigned VELOCITY_MAX = 127
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        advance_i,
  input  wire scpc_pkg::in_item_t          item_i,
  input  wire logic [scpc_pkg::ChanW-1:0]  channel_id_i,
  input  wire logic                        stop_on_seq_halt_i,
  output scpc_pkg::out_data_t              result_o
);
  import scpc_pkg::*;

  localparam int unsigned VelCount = 1 << VelW;
  localparam int unsigned VolMax   = (1 << VolW) - 1;

  status_e         status_q, status_d;
  logic [VolW-1:0] vol_table [VelCount];
  logic [1:0]      rc;
  logic [1:0]      qr;
  logic [13:0]     aid;
  logic            vol_valid;
  logic [VolW-1:0] vol;
  logic            rew;
  in_data_t        d;

  // Rounded velocity to Q0.16 volume map, saturated at full scale.
  for (genvar gi = 0; gi < VelCount; gi++) begin : g_vol
    localparam int unsigned Raw = (gi * (VolMax + 1) + VELOCITY_MAX / 2) / VELOCITY_MAX;
    localparam int unsigned Sat = (Raw > VolMax) ? VolMax : Raw;
    assign vol_table[gi] = VolW'(Sat);
  end

  assign d = item_i.data;

  // Next status and commands for the event in the input register.
  always_comb begin
    status_d  = status_q;
    rc        = RcNone;
    qr        = QrNone;
    aid       = '0;
    vol_valid = 1'b0;
    vol       = '0;
    rew       = 1'b0;
    unique case (item_i.mode)
      EvPress: begin
        unique case (status_q)
          StOff: begin
            if (d.is_loop) begin
              status_d = StWait;
            end else begin
              if (d.velocity_as_volume) begin
                vol_valid = 1'b1;
                vol       = vol_table[d.velocity];
              end
              if (d.can_quantize) begin
                qr       = QrPlay;
                aid      = ActionPlayBase + {2'b00, channel_id_i};
                status_d = StOff;
              end else begin
                status_d = StPlay;
              end
            end
          end
          StPlay: begin
            if (d.is_loop) begin
              status_d = StEnding;
            end else if (d.player_mode == PmRetrig) begin
              if (d.can_quantize) begin
                qr  = QrRewind;
                aid = ActionRewindBase + {2'b00, channel_id_i};
              end else begin
                rc = RcRewind;
              end
            end else if (d.player_mode == PmEndless) begin
              status_d = StEnding;
            end else if (d.player_mode == PmBasic) begin
              rc = RcStop;
            end else begin
              status_d = StOff;
            end
          end
          StWait: begin
            status_d = StOff;
          end
          StEnding: begin
            status_d = StPlay;
          end
          default: begin
            status_d = status_q;
          end
        endcase
      end
      EvKill: begin
        if (status_q == StPlay || status_q == StEnding) begin
          rc = RcStop;
        end
        if (d.player_mode == PmBasicPause) begin
          rew = 1'b1;
        end
      end
      EvRelease: begin
        if (d.player_mode == PmPress) begin
          if (status_q == StPlay) begin
            rc = RcStop;
          end else if (d.quantize_pending) begin
            qr = QrClear;
          end
        end
      end
      EvSeqStop: begin
        if (status_q == StWait) begin
          if (d.is_loop) begin
            status_d = StOff;
          end
        end else if (status_q == StPlay) begin
          if (stop_on_seq_halt_i && (d.is_loop || d.reading_actions)) begin
            rc = RcStop;
          end
        end
      end
      EvLoad: begin
        status_d = status_e'(d.new_status);
      end
      default: begin
        status_d = status_q;
      end
    endcase
  end

  always_comb begin
    result_o.status           = status_d;
    result_o.render_command   = rc;
    result_o.quantize_request = qr;
    result_o.action_id        = aid;
    result_o.volume_valid     = vol_valid;
    result_o.volume           = vol;
    result_o.rewind_to_start  = rew;
  end

  // Status moves only when the event is handed to the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= StOff;
    end else if (advance_i) begin
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/scpc_out_stage.sv @@
// Output register that holds one result beat until the receiver takes it.
`default_nettype none

module scpc_out_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire scpc_pkg::out_data_t  result_i,
  output logic                      free_o,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output scpc_pkg::out_data_t       result_o
);
  import scpc_pkg::*;

  logic      valid_q;
  out_data_t result_q;

  // Room for a new result when empty or when the held beat leaves now.
  assign free_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/scpc_checker.sv @@
// Port-level checks of the sampler channel play controller and their binding.
`default_nettype none

module scpc_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [scpc_pkg::OutTdataW-1:0] m_axis_tdata
);
  import scpc_pkg::*;

  out_data_t res;

  assign res = out_data_t'(m_axis_tdata[OutDataW-1:0]);

  // A stalled result beat stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // Volume reads zero unless it carries a new value.
  a_volume_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.volume_valid |-> res.volume == '0)
    else $error("volume set without volume_valid");

  // An action code goes only with a trigger request.
  a_action_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.quantize_request == QrNone || res.quantize_request == QrClear)
    |-> res.action_id == '0)
    else $error("action id without trigger request");

  // A quantized rewind is only issued to a channel that keeps playing.
  a_rewind_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.quantize_request == QrRewind |-> res.status == StPlay)
    else $error("trigger rewind outside play");

  // Render command never takes the unused code.
  a_render_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.render_command != 2'd3)
    else $error("unused render command code");

endmodule

bind sample_channel_play_control scpc_checker u_scpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ test/scpc_play_checker.sv @@
// Checker for the sampler channel play controller: predicts every result beat and compares it.
`default_nettype none

module scpc_play_checker
  import scpc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  input  wire logic                  s_tready_i,
  // Fields from bit 0: player_mode, velocity, can_quantize, is_loop,
  // velocity_as_volume, quantize_pending, reading_actions, new_status.
  input  wire logic [InTdataW-1:0]   s_tdata_i,
  // Fields from bit 0: mode.
  input  wire logic [2:0]            s_tuser_i,
  input  wire logic                  m_tvalid_i,
  input  wire logic                  m_tready_i,
  // Fields from bit 0: status, render_command, quantize_request, action_id,
  // volume_valid, volume, rewind_to_start.
  input  wire logic [OutTdataW-1:0]  m_tdata_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [CfgDataW-1:0]   cfg_data_i,
  output int                         fail_count_o,
  output int                         outstanding_o
);

  // Velocity full scale of the block under test (its default parameter).
  localparam int unsigned VelocityMax = 127;

  // Own copy of the configuration and of the play status.
  logic [ChanW-1:0] chan_id;
  logic             halt_stops_play;
  status_e          play_state;

  // Results still owed by the block, oldest first.
  out_data_t        owed_results[$];
  int               errors;

  // Work out the result of one event from the current status and configuration.
  function automatic out_data_t predict_event(input logic [2:0] kind, input in_data_t f);
    out_data_t   r;
    status_e     st;
    int unsigned vol;
    r = '0;
    st = play_state;
    case (kind)
      EvPress: begin
        case (st)
          StOff: begin
            if (f.is_loop) begin
              st = StWait;
            end else begin
              if (f.velocity_as_volume) begin
                // Rounded map of velocity onto Q0.16, saturated below 1.0.
                vol = (int'(f.velocity) * 65536 + VelocityMax / 2) / VelocityMax;
                r.volume_valid = 1'b1;
                r.volume = (vol > 65535) ? 16'hFFFF : vol[15:0];
              end
              if (f.can_quantize) begin
                r.quantize_request = QrPlay;
                r.action_id = ActionPlayBase + {2'b00, chan_id};
              end else begin
                st = StPlay;
              end
            end
          end
          StPlay: begin
            if (f.is_loop) begin
              st = StEnding;
            end else begin
              case (f.player_mode)
                PmRetrig: begin
                  if (f.can_quantize) begin
                    r.quantize_request = QrRewind;
                    r.action_id = ActionRewindBase + {2'b00, chan_id};
                  end else begin
                    r.render_command = RcRewind;
                  end
                end
                PmEndless: st = StEnding;
                PmBasic: r.render_command = RcStop;
                default: st = StOff;
              endcase
            end
          end
          StWait: st = StOff;
          default: st = StPlay;
        endcase
      end
      EvKill: begin
        if (st == StPlay || st == StEnding) r.render_command = RcStop;
        if (f.player_mode == PmBasicPause) r.rewind_to_start = 1'b1;
      end
      EvRelease: begin
        if (f.player_mode == PmPress) begin
          if (st == StPlay) r.render_command = RcStop;
          else if (f.quantize_pending) r.quantize_request = QrClear;
        end
      end
      EvSeqStop: begin
        if (st == StWait) begin
          if (f.is_loop) st = StOff;
        end else if (st == StPlay) begin
          if (halt_stops_play && (f.is_loop || f.reading_actions)) r.render_command = RcStop;
        end
      end
      EvLoad: st = status_e'(f.new_status);
      default: ;
    endcase
    r.status = st;
    return r;
  endfunction

  // Report one field that differs from its prediction.
  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Watch all three channels at each edge: configuration first, then results, then new events.
  always @(posedge clk_i or negedge rst_ni) begin
    out_data_t want;
    out_data_t got;
    if (!rst_ni) begin
      owed_results.delete();
      chan_id = '0;
      halt_stops_play = 1'b0;
      play_state = StOff;
      errors = 0;
      fail_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgChannelId: chan_id = cfg_data_i[ChanW-1:0];
          CfgStopOnSeqHalt: halt_stops_play = cfg_data_i[0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[OutDataW-1:0];
        if (owed_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, m_tdata_i);
          errors++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("render_command", want.render_command, got.render_command);
          check_field("quantize_request", want.quantize_request, got.quantize_request);
          check_field("action_id", want.action_id, got.action_id);
          check_field("volume_valid", want.volume_valid, got.volume_valid);
          check_field("volume", want.volume, got.volume);
          check_field("rewind_to_start", want.rewind_to_start, got.rewind_to_start);
          check_field("tdata fill", 0, m_tdata_i[OutTdataW-1:OutDataW]);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        want = predict_event(s_tuser_i, s_tdata_i[InDataW-1:0]);
        play_state = want.status;
        owed_results.push_back(want);
      end
      fail_count_o <= errors;
      outstanding_o <= owed_results.size();
    end
  end

endmodule

`default_nettype wire

@@ test/tb_sample_channel_play_control.sv @@
// Testbench top for the sampler channel play controller: stimulus, back-pressure and verdict.
`default_nettype none

module tb_sample_channel_play_control;
  import scpc_pkg::*;

  localparam int NumPhases     = 6;
  localparam int ItemsPerPhase = 250;
  localparam int HoldAt        = 700;
  localparam int HoldCycles    = 300;
  localparam int CalmFrom      = 1000;
  localparam int CalmTo        = 1250;
  localparam int WatchdogLimit = 3000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic [2:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  int   fail_count;
  int   outstanding;
  int   events_taken;
  int   quiet_cycles;
  int   hold_left;
  logic hold_done;
  logic calm;

  always #2 clk_i = ~clk_i;

  sample_channel_play_control u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  scpc_play_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Both sides stop idling for a stretch in the middle of the run.
  assign calm = (events_taken >= CalmFrom) && (events_taken < CalmTo);

  // Count accepted event beats; the receiver and the sender pace themselves on it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      events_taken <= 0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      events_taken <= events_taken + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && events_taken == HoldAt) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 26);
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_data_t make_fields(input logic [2:0] pm, input logic [VelW-1:0] vel,
                                           input logic quant, input logic loop,
                                           input logic vel_vol, input logic pending,
                                           input logic reading, input logic [1:0] ns);
    in_data_t f;
    f.player_mode = pm;
    f.velocity = vel;
    f.can_quantize = quant;
    f.is_loop = loop;
    f.velocity_as_volume = vel_vol;
    f.quantize_pending = pending;
    f.reading_actions = reading;
    f.new_status = ns;
    return f;
  endfunction

  // Offer one event beat after an optional idle gap and wait until it is taken.
  task automatic send_event(input logic [2:0] kind, input in_data_t f);
    logic [InTdataW-1:0] word;
    word = '0;
    word[InDataW-1:0] = f;
    if (!calm && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 26);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Random event, weighted toward the kinds that move the status.
  task automatic send_random_event();
    logic [2:0]  kind;
    logic [31:0] bits;
    in_data_t    f;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 34)      kind = EvPress;
    else if (pick < 46) kind = EvKill;
    else if (pick < 60) kind = EvRelease;
    else if (pick < 75) kind = EvSeqStop;
    else if (pick < 91) kind = EvLoad;
    else                kind = 3'($urandom_range(7, EvLoad + 1));
    bits = $urandom;
    f = bits[InDataW-1:0];
    // Push the velocity to its ends now and then.
    if ($urandom_range(7) == 0) f.velocity = $urandom_range(1) ? '1 : '0;
    send_event(kind, f);
  endtask

  // One configuration write; the channel drops between writes.
  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Directed events under channel id 4095 with stop on sequencer halt set.
  task automatic run_directed();
    send_event(EvPress, make_fields(PmBasic, '0, 0, 1, 0, 0, 0, StOff));     // off, loop: wait
    send_event(EvSeqStop, make_fields(PmBasic, '0, 0, 0, 0, 0, 0, StOff));   // wait stays
    send_event(EvSeqStop, make_fields(PmBasic, '0, 0, 1, 0, 0, 0, StOff));   // wait, loop: off
    send_event(EvPress, make_fields(PmBasic, '1, 1, 0, 1, 0, 0, StOff));     // quantized play
    send_event(EvPress, make_fields(PmBasic, '0, 0, 0, 1, 0, 0, StOff));     // play, volume 0
    send_event(EvPress, make_fields(PmRetrig, '0, 1, 0, 0, 0, 0, StOff));    // quantized rewind
    send_event(EvPress, make_fields(PmRetrig, '0, 0, 0, 0, 0, 0, StOff));    // render rewind
    send_event(EvPress, make_fields(PmBasic, '0, 0, 0, 0, 0, 0, StOff));     // basic stop
    send_event(EvSeqStop, make_fields(PmBasic, '0, 0, 0, 0, 0, 1, StOff));   // halt stops play
    send_event(EvKill, make_fields(PmBasicPause, '0, 0, 0, 0, 0, 0, StOff)); // stop and rewind
    send_event(EvRelease, make_fields(PmPress, '0, 0, 0, 0, 0, 0, StOff));   // release stops
    send_event(EvPress, make_fields(PmEndless, '0, 0, 0, 0, 0, 0, StOff));   // play to ending
    send_event(EvKill, make_fields(PmBasic, '0, 0, 0, 0, 0, 0, StOff));      // kill in ending
    send_event(EvPress, make_fields(PmBasic, '0, 0, 0, 0, 0, 0, StOff));     // ending to play
    send_event(EvPress, make_fields(PmBasic, '0, 0, 1, 0, 0, 0, StOff));     // loop to ending
    send_event(EvLoad, make_fields(PmBasic, '0, 0, 0, 0, 0, 0, StPlay));
    send_event(EvPress, make_fields('1, '1, 0, 0, 0, 0, 0, StOff));          // other mode: off
    send_event(EvRelease, make_fields(PmPress, '0, 0, 0, 0, 1, 0, StOff));   // clear pending
    send_event(EvRelease, make_fields(PmPress, '0, 0, 0, 0, 0, 0, StOff));   // nothing pending
    send_event(EvKill, make_fields(PmBasicPause, '0, 0, 0, 0, 0, 0, StOff)); // rewind only
    send_event('1, make_fields('1, '1, 1, 1, 1, 1, 1, StEnding));            // unused code
    send_event(EvLoad, make_fields(PmBasic, '0, 0, 0, 0, 0, 0, StWait));
    send_event(EvPress, make_fields(PmBasic, '0, 0, 0, 0, 0, 0, StOff));     // wait to off
    send_event(EvLoad, make_fields(PmBasic, '0, 0, 0, 0, 0, 0, StEnding));
    send_event(EvLoad, make_fields('1, '1, 1, 1, 1, 1, 1, StOff));
  endtask

  // Main sequence: reset, then phases of configuration and events.
  initial begin
    logic [ChanW-1:0]    chan;
    logic [CfgDataW-1:0] halt_word;
    logic                halt;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       begin chan = '1; halt = 1'b1; end
        1:       begin chan = '0; halt = 1'b0; end
        3:       begin chan = '1; halt = 1'b0; end
        4:       begin chan = '0; halt = 1'b1; end
        default: begin chan = ChanW'($urandom); halt = 1'($urandom_range(1)); end
      endcase
      // Upper bits of the halt register word carry noise.
      halt_word = CfgDataW'($urandom);
      halt_word[0] = halt;
      write_cfg(CfgChannelId, chan);
      write_cfg(CfgStopOnSeqHalt, halt_word);
      if (phase == 0) run_directed();
      repeat (ItemsPerPhase) send_random_event();
      s_axis_tvalid <= 1'b0;
      // Let every owed result drain before the next configuration.
      do @(posedge clk_i); while (outstanding != 0);
      repeat (4) @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
